// ----- src/risc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_pkg
// Shared constants, opcode and function codes, state and command types for
// the instruction step core.
// ----------------------------------------------------------------------------
package risc_pkg;

  localparam int unsigned MEM_BYTES = 16384;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned BANK_ROWS = MEM_BYTES / 4;
  localparam int unsigned ROW_AW    = MEM_AW - 2;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LWR     = 6'd38;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_MOVZ  = 6'd10;
  localparam logic [5:0] FN_MOVN  = 6'd11;
  localparam logic [5:0] FN_BREAK = 6'd13;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_NOR   = 6'd39;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;
  localparam logic [5:0] FN_TGE   = 6'd48;
  localparam logic [5:0] FN_TGEU  = 6'd49;
  localparam logic [5:0] FN_TLT   = 6'd50;
  localparam logic [5:0] FN_TLTU  = 6'd51;
  localparam logic [5:0] FN_TEQ   = 6'd52;
  localparam logic [5:0] FN_TNE   = 6'd54;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_TRAP  = 2'd1;
  localparam logic [1:0] STATUS_BREAK = 2'd2;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_EXEC, ST_LOAD, ST_MUL, ST_DIV, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE, KIND_LOAD, KIND_MUL, KIND_DIV
  } kind_e;

  typedef struct packed {
    logic clear;
    logic mem_write;
    logic fetch;
    logic decode;
    logic exec;
    logic load_wb;
    logic mul_wb;
    logic div_wb;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic  clear_done;
    kind_e kind;
    logic  div_done;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/risc_instruction_step_core_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_instruction_step_core_top
// Multicycle MIPS-style core with a 16 KiB little-endian byte memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): mode_i = 0 writes load_data_i as a
// little-endian word at load_address_i; mode_i = 1 executes the instruction
// at PC. Each transaction gives exactly one result transaction on the output
// channel (out_valid_o/out_ready_i, fields held until taken).
// Sequence: a memory write goes through accept and done to the output
// register; an ordinary instruction through accept/fetch, decode, execute
// and done; loads and multiplies add a memory read or product writeback
// state; divides by a nonzero divisor wait on the one-bit-per-cycle
// divider. One item is in work at a time; the next is accepted once the
// previous result sits in the output register, even if not yet taken.
// Reset: after rst_ni rises, a clearing pass zeroes the memory one row of
// four bytes per cycle, while in_ready_o stays low. Registers, PC, HI and
// LO read as zero after reset.
// A stalled receiver holds the output register; the core finishes the item
// in work and then waits in its done state.
// ----------------------------------------------------------------------------
module risc_instruction_step_core_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [13:0] load_address_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [19:0] break_code_o,
  output logic [31:0] program_counter_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o
);
  import risc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  risc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  risc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .load_address_i    (load_address_i),
    .load_data_i       (load_data_i),
    .status_o          (status_o),
    .break_code_o      (break_code_o),
    .program_counter_o (program_counter_o),
    .reg_written_o     (reg_written_o),
    .reg_index_o       (reg_index_o),
    .reg_value_o       (reg_value_o)
  );

endmodule
`default_nettype wire

// ----- src/risc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module risc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  localparam int unsigned STEPS = 32;
  localparam int unsigned CW    = $clog2(STEPS);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, quo_q, dvs_q;
  logic [32:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- src/risc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_ctrl
// Sequencer: memory clear after reset, memory writes, fetch, decode, execute,
// memory or multiply/divide writeback, and hand-off to the output register.
// ----------------------------------------------------------------------------
module risc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 mode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  risc_pkg::stat_t      stat_i,
  output risc_pkg::cmd_t       cmd_o
);
  import risc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = mode_i ? ST_DECODE : ST_DONE;
      ST_DECODE: state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (stat_i.kind)
          KIND_LOAD: state_d = ST_LOAD;
          KIND_MUL:  state_d = ST_MUL;
          KIND_DIV:  state_d = ST_DIV;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_LOAD:   state_d = ST_DONE;
      ST_MUL:    state_d = ST_DONE;
      ST_DIV:    if (stat_i.div_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.mem_write = accept && !mode_i;
        cmd_o.fetch     = accept && mode_i;
      end
      ST_DECODE: cmd_o.decode  = 1'b1;
      ST_EXEC:   cmd_o.exec    = 1'b1;
      ST_LOAD:   cmd_o.load_wb = 1'b1;
      ST_MUL:    cmd_o.mul_wb  = 1'b1;
      ST_DIV:    cmd_o.div_wb  = stat_i.div_done;
      ST_DONE:   cmd_o.publish = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/risc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_dp
// Datapath: four byte banks, register file, PC/HI/LO, ALU, multiplier,
// divider and the result/output registers.
// ----------------------------------------------------------------------------
module risc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  risc_pkg::cmd_t       cmd_i,
  output risc_pkg::stat_t      stat_o,
  input  logic [13:0]          load_address_i,
  input  logic [31:0]          load_data_i,
  output logic [1:0]           status_o,
  output logic [19:0]          break_code_o,
  output logic [31:0]          program_counter_o,
  output logic                 reg_written_o,
  output logic [4:0]           reg_index_o,
  output logic [31:0]          reg_value_o
);
  import risc_pkg::*;

  logic [31:0] pc_q, hi_q, lo_q;

  // ---------------- byte memory, word-interleaved over four banks ----------
  logic [ROW_AW-1:0] clr_cnt_q;
  logic              clr_done_q;
  logic [MEM_AW-1:0] acc_base, ld_base;
  logic [ROW_AW-1:0] bank_addr [4];
  logic [7:0]        bank_wd   [4];
  logic [7:0]        bank_rd_q [4];
  logic              bank_we;
  logic [1:0]        rd_base_q;
  logic [31:0]       rd_word;
  logic [31:0]       la32;

  assign la32    = 32'(load_address_i);
  assign bank_we = cmd_i.clear || cmd_i.mem_write;

  always_comb begin
    if (cmd_i.mem_write)  acc_base = la32[MEM_AW-1:0];
    else if (cmd_i.fetch) acc_base = pc_q[MEM_AW-1:0];
    else                  acc_base = ld_base;
  end

  always_comb begin
    logic [1:0]        kb;
    logic [MEM_AW-1:0] sum;
    for (int b = 0; b < 4; b++) begin
      kb  = 2'(b) - acc_base[1:0];
      sum = acc_base + MEM_AW'(kb);
      if (cmd_i.clear) begin
        bank_addr[b] = clr_cnt_q;
        bank_wd[b]   = 8'h00;
      end else begin
        bank_addr[b] = sum[MEM_AW-1:2];
        bank_wd[b]   = 8'(load_data_i >> {kb, 3'b000});
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [BANK_ROWS];
    always_ff @(posedge clk_i) begin
      if (bank_we) mem[bank_addr[g]] <= bank_wd[g];
      bank_rd_q[g] <= mem[bank_addr[g]];
    end
  end

  always_comb begin
    logic [1:0] sel;
    for (int k = 0; k < 4; k++) begin
      sel = rd_base_q + 2'(k);
      rd_word[8*k +: 8] = bank_rd_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
      rd_base_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ROW_AW'(BANK_ROWS - 1)) clr_done_q <= 1'b1;
      end
      rd_base_q <= acc_base[1:0];
    end
  end

  // ---------------- architectural registers ------------------------------
  logic [31:0] ins_q;
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] ra_q, rb_q;
  logic        a_vld_q, b_vld_q;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [31:0] a, b;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (cmd_i.decode) begin
      ra_q <= rf_mem[rd_word[25:21]];
      rb_q <= rf_mem[rd_word[20:16]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (cmd_i.decode) begin
        a_vld_q <= rf_vld_q[rd_word[25:21]];
        b_vld_q <= rf_vld_q[rd_word[20:16]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) ins_q <= rd_word;
  end

  assign a = a_vld_q ? ra_q : 32'h0;
  assign b = b_vld_q ? rb_q : 32'h0;

  // ---------------- execute ------------------------------------------------
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, ea, nxt, sum_ab, dif_ab, sum_ai;
  logic        lt_s, lt_u;
  logic [1:0]  ex_status;
  logic        ex_wr;
  logic [4:0]  ex_idx;
  logic [31:0] ex_val, ex_next;
  logic        ex_hi_we, ex_lo_we;
  kind_e       ex_kind;

  assign op     = ins_q[31:26];
  assign rs     = ins_q[25:21];
  assign rt     = ins_q[20:16];
  assign rd     = ins_q[15:11];
  assign sh     = ins_q[10:6];
  assign fn     = ins_q[5:0];
  assign imm    = {16'h0, ins_q[15:0]};
  assign simm   = {{16{ins_q[15]}}, ins_q[15:0]};
  assign ea     = a + simm;
  assign nxt    = pc_q + 32'd4;
  assign sum_ab = a + b;
  assign dif_ab = a - b;
  assign sum_ai = a + simm;
  assign lt_s   = $signed(a) < $signed(b);
  assign lt_u   = a < b;

  always_comb begin
    ex_status = STATUS_OK;
    ex_wr     = 1'b0;
    ex_idx    = rd;
    ex_val    = 32'h0;
    ex_next   = nxt;
    ex_hi_we  = 1'b0;
    ex_lo_we  = 1'b0;
    ex_kind   = KIND_SIMPLE;
    ld_base   = ea[MEM_AW-1:0];
    if (op == OP_SPECIAL) begin
      unique case (fn)
        FN_SLL:  begin ex_wr = 1'b1; ex_val = b << sh; end
        FN_SRL:  begin ex_wr = 1'b1; ex_val = b >> sh; end
        FN_SRA:  begin ex_wr = 1'b1; ex_val = 32'($signed(b) >>> sh); end
        FN_SLLV: begin ex_wr = 1'b1; ex_val = b << a[4:0]; end
        FN_SRLV: begin ex_wr = 1'b1; ex_val = b >> a[4:0]; end
        FN_SRAV: begin ex_wr = 1'b1; ex_val = 32'($signed(b) >>> a[4:0]); end
        FN_JR:   ex_next = a;
        FN_JALR: begin ex_wr = 1'b1; ex_idx = REG_RA; ex_val = nxt; ex_next = a; end
        FN_MOVZ: begin ex_wr = (b == 32'h0); ex_val = a; end
        FN_MOVN: begin ex_wr = (b != 32'h0); ex_val = a; end
        FN_BREAK: ex_status = STATUS_BREAK;
        FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_q; end
        FN_MTHI: ex_hi_we = 1'b1;
        FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_q; end
        FN_MTLO: ex_lo_we = 1'b1;
        FN_MULT, FN_MULTU: ex_kind = KIND_MUL;
        FN_DIV, FN_DIVU: if (b != 32'h0) ex_kind = KIND_DIV;
        FN_ADD: begin
          ex_val = sum_ab;
          if (((a ^ sum_ab) & (b ^ sum_ab)) >> 31 != 32'h0) ex_status = STATUS_TRAP;
          else ex_wr = 1'b1;
        end
        FN_ADDU: begin ex_wr = 1'b1; ex_val = sum_ab; end
        FN_SUB: begin
          ex_val = dif_ab;
          if (((a ^ b) & (a ^ dif_ab)) >> 31 != 32'h0) ex_status = STATUS_TRAP;
          else ex_wr = 1'b1;
        end
        FN_SUBU: begin ex_wr = 1'b1; ex_val = dif_ab; end
        FN_AND:  begin ex_wr = 1'b1; ex_val = a & b; end
        FN_OR:   begin ex_wr = 1'b1; ex_val = a | b; end
        FN_XOR:  begin ex_wr = 1'b1; ex_val = a ^ b; end
        FN_NOR:  begin ex_wr = 1'b1; ex_val = ~(a | b); end
        FN_SLT:  begin ex_wr = 1'b1; ex_val = 32'(lt_s); end
        FN_SLTU: begin ex_wr = 1'b1; ex_val = 32'(lt_u); end
        FN_TGE:  if (!lt_s) ex_status = STATUS_TRAP;
        FN_TGEU: if (!lt_u) ex_status = STATUS_TRAP;
        FN_TLT:  if (lt_s) ex_status = STATUS_TRAP;
        FN_TLTU: if (lt_u) ex_status = STATUS_TRAP;
        FN_TEQ:  if (a == b) ex_status = STATUS_TRAP;
        FN_TNE:  if (a != b) ex_status = STATUS_TRAP;
        default: ex_wr = 1'b0;
      endcase
    end else begin
      ex_idx = rt;
      unique case (op)
        OP_J:   ex_next = {pc_q[31:28], ins_q[25:0], 2'b00};
        OP_JAL: begin
          ex_wr = 1'b1; ex_idx = REG_RA; ex_val = nxt;
          ex_next = {pc_q[31:28], ins_q[25:0], 2'b00};
        end
        OP_BEQ:  if (a == b) ex_next = pc_q + (simm << 2);
        OP_BNE:  if (a != b) ex_next = pc_q + (simm << 2);
        OP_BLEZ: if (a == 32'h0 || a[31]) ex_next = pc_q + (simm << 2);
        OP_BGTZ: if (a != 32'h0 && !a[31]) ex_next = pc_q + (simm << 2);
        OP_ADDI: begin
          ex_val = sum_ai;
          if (((a ^ sum_ai) & (simm ^ sum_ai)) >> 31 != 32'h0) ex_status = STATUS_TRAP;
          else ex_wr = 1'b1;
        end
        OP_ADDIU: begin ex_wr = 1'b1; ex_val = sum_ai; end
        OP_SLTI:  begin ex_wr = 1'b1; ex_val = 32'($signed(a) < $signed(simm)); end
        OP_SLTIU: begin ex_wr = 1'b1; ex_val = 32'(a < simm); end
        OP_ANDI:  begin ex_wr = 1'b1; ex_val = a & imm; end
        OP_ORI:   begin ex_wr = 1'b1; ex_val = a | imm; end
        OP_XORI:  begin ex_wr = 1'b1; ex_val = a ^ imm; end
        OP_LUI:   begin ex_wr = 1'b1; ex_val = {ins_q[15:0], 16'h0}; end
        OP_LB:    ex_kind = KIND_LOAD;
        OP_LH: begin
          if (ea[0]) ex_status = STATUS_TRAP;
          else ex_kind = KIND_LOAD;
        end
        OP_LWL, OP_LWR: begin
          ex_kind = KIND_LOAD;
          ld_base = {ea[MEM_AW-1:2], 2'b00};
        end
        default: ex_wr = 1'b0;
      endcase
    end
  end

  // ---------------- multiply and divide ----------------------------------
  logic        msgn;
  logic [65:0] mprod;
  logic [63:0] prod_q;
  logic        dsgn, qneg_q, rneg_q;
  logic [31:0] ua, ub, dquo, drem;
  logic        div_start, div_done;

  assign msgn  = (fn == FN_MULT);
  assign mprod = 66'($signed({msgn & a[31], a}) * $signed({msgn & b[31], b}));
  assign dsgn  = (fn == FN_DIV);
  assign ua    = (dsgn && a[31]) ? (32'h0 - a) : a;
  assign ub    = (dsgn && b[31]) ? (32'h0 - b) : b;
  assign div_start = cmd_i.exec && (ex_kind == KIND_DIV);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      prod_q <= mprod[63:0];
      qneg_q <= dsgn && (a[31] ^ b[31]);
      rneg_q <= dsgn && a[31];
    end
  end

  risc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ua),
    .divisor_i  (ub),
    .done_o     (div_done),
    .quo_o      (dquo),
    .rem_o      (drem)
  );

  // ---------------- load writeback ----------------------------------------
  logic [31:0] ld_val;
  logic [1:0]  ea_lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) ea_lo_q <= ea[1:0];
  end

  always_comb begin
    unique case (op)
      OP_LB:   ld_val = {{24{rd_word[7]}}, rd_word[7:0]};
      OP_LH:   ld_val = {{16{rd_word[15]}}, rd_word[15:0]};
      OP_LWL:  ld_val = rd_word << {~ea_lo_q, 3'b000};
      default: ld_val = rd_word >> {ea_lo_q, 3'b000};
    endcase
  end

  // ---------------- register file write, state and results ---------------
  logic [1:0]  res_status_q;
  logic [19:0] res_code_q;
  logic        res_wr_q;
  logic [4:0]  res_idx_q;
  logic [31:0] res_val_q;
  logic        ex_commit;

  assign ex_commit = ex_wr && (ex_idx != 5'd0) && (ex_status == STATUS_OK);

  always_comb begin
    rf_we = 1'b0;
    rf_wa = ex_idx;
    rf_wd = ex_val;
    if (cmd_i.exec) begin
      rf_we = ex_commit;
    end else if (cmd_i.load_wb) begin
      rf_we = (rt != 5'd0);
      rf_wa = rt;
      rf_wd = ld_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        if (ex_status == STATUS_OK) pc_q <= ex_next;
        if (ex_hi_we) hi_q <= a;
        if (ex_lo_we) lo_q <= a;
      end
      if (cmd_i.mul_wb) begin
        hi_q <= prod_q[63:32];
        lo_q <= prod_q[31:0];
      end
      if (cmd_i.div_wb) begin
        lo_q <= qneg_q ? (32'h0 - dquo) : dquo;
        hi_q <= rneg_q ? (32'h0 - drem) : drem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      res_status_q <= STATUS_OK;
      res_code_q   <= '0;
      res_wr_q     <= 1'b0;
      res_idx_q    <= '0;
      res_val_q    <= '0;
    end else if (cmd_i.exec) begin
      res_status_q <= ex_status;
      res_code_q   <= (ex_status == STATUS_BREAK) ? {rs, rt, rd, sh} : 20'h0;
      res_wr_q     <= ex_commit;
      res_idx_q    <= ex_commit ? ex_idx : 5'd0;
      res_val_q    <= ex_commit ? ex_val : 32'h0;
    end else if (cmd_i.load_wb) begin
      res_wr_q  <= (rt != 5'd0);
      res_idx_q <= rt;
      res_val_q <= (rt != 5'd0) ? ld_val : 32'h0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      status_o          <= res_status_q;
      break_code_o      <= res_code_q;
      program_counter_o <= pc_q;
      reg_written_o     <= res_wr_q;
      reg_index_o       <= res_idx_q;
      reg_value_o       <= res_val_q;
    end
  end

  assign stat_o.clear_done = clr_done_q;
  assign stat_o.kind       = ex_kind;
  assign stat_o.div_done   = div_done;

endmodule
`default_nettype wire

// ----- tb/tb_risc_instruction_step_core_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_risc_instruction_step_core_top
// Self-checking bench for the instruction step core. Memory-write and step
// transactions go into the core; a behavioral model of the core predicts each
// result, and the monitor compares it field by field.
// ----------------------------------------------------------------------------
module tb_risc_instruction_step_core_top;
  import risc_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [13:0] addr;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] code;
    logic [31:0] pc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
  } step_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [13:0] load_address_i;
  logic [31:0] load_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [19:0] break_code_o;
  logic [31:0] program_counter_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;

  risc_instruction_step_core_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .load_address_i,
    .load_data_i, .out_valid_o, .out_ready_i, .status_o, .break_code_o,
    .program_counter_o, .reg_written_o, .reg_index_o, .reg_value_o
  );

  // model state
  logic [7:0]  mdl_mem [MEM_BYTES];
  logic [31:0] mdl_gpr [32];
  logic [31:0] mdl_pc, mdl_hi, mdl_lo;

  item_t     pending_q[$];
  step_res_t expected_q[$];
  int        errors;
  int        idle_pct_in, stall_pct_out;
  int        hold_req  = 0;
  int        hold_ack  = 0;
  int        hold_cnt  = 0;
  bit        stim_done;
  int        quiet_cycles;
  int        n_queued, n_checked;

  // test-side program counter tracking, for placing instructions
  logic [31:0] gen_pc;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] mem_word(logic [31:0] a);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) w[8*k +: 8] = mdl_mem[(a + k) % MEM_BYTES];
    return w;
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Predict one result and advance the model state.
  function automatic step_res_t core_step(item_t it);
    step_res_t r;
    logic [31:0] ins, a, b, nxt, simm, ea, s, w, q, rm, ua, ub;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [63:0] p;
    logic wr;
    logic [4:0] wi;
    logic [31:0] wv;
    r = '0;
    wr = 0; wi = 0; wv = 0;
    if (!it.mode) begin
      for (int k = 0; k < 4; k++) mdl_mem[(it.addr + k) % MEM_BYTES] = it.data[8*k +: 8];
    end else begin
      ins = mem_word(mdl_pc);
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sh = ins[10:6]; fn = ins[5:0];
      simm = sx16(ins[15:0]);
      a = mdl_gpr[rs]; b = mdl_gpr[rt];
      nxt = mdl_pc + 4;
      ea = a + simm;
      if (op == OP_SPECIAL) begin
        case (fn)
          FN_SLL:  begin wr = 1; wi = rd; wv = b << sh; end
          FN_SRL:  begin wr = 1; wi = rd; wv = b >> sh; end
          FN_SRA:  begin wr = 1; wi = rd; wv = $signed(b) >>> sh; end
          FN_SLLV: begin wr = 1; wi = rd; wv = b << a[4:0]; end
          FN_SRLV: begin wr = 1; wi = rd; wv = b >> a[4:0]; end
          FN_SRAV: begin wr = 1; wi = rd; wv = $signed(b) >>> a[4:0]; end
          FN_JR:   nxt = a;
          FN_JALR: begin wr = 1; wi = REG_RA; wv = mdl_pc + 4; nxt = a; end
          FN_MOVZ: if (b == 0) begin wr = 1; wi = rd; wv = a; end
          FN_MOVN: if (b != 0) begin wr = 1; wi = rd; wv = a; end
          FN_BREAK: begin
            r.status = STATUS_BREAK;
            r.code = {rs, rt, rd, sh};
          end
          FN_MFHI: begin wr = 1; wi = rd; wv = mdl_hi; end
          FN_MTHI: mdl_hi = a;
          FN_MFLO: begin wr = 1; wi = rd; wv = mdl_lo; end
          FN_MTLO: mdl_lo = a;
          FN_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            mdl_lo = p[31:0]; mdl_hi = p[63:32];
          end
          FN_MULTU: begin
            p = {32'd0, a} * {32'd0, b};
            mdl_lo = p[31:0]; mdl_hi = p[63:32];
          end
          FN_DIV: if (b != 0) begin
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub; rm = ua % ub;
            mdl_lo = (a[31] != b[31]) ? -q : q;
            mdl_hi = a[31] ? -rm : rm;
          end
          FN_DIVU: if (b != 0) begin mdl_lo = a / b; mdl_hi = a % b; end
          FN_ADD: begin
            s = a + b;
            if ((a[31] == b[31]) && (s[31] != a[31])) r.status = STATUS_TRAP;
            else begin wr = 1; wi = rd; wv = s; end
          end
          FN_ADDU: begin wr = 1; wi = rd; wv = a + b; end
          FN_SUB: begin
            s = a - b;
            if ((a[31] != b[31]) && (s[31] != a[31])) r.status = STATUS_TRAP;
            else begin wr = 1; wi = rd; wv = s; end
          end
          FN_SUBU: begin wr = 1; wi = rd; wv = a - b; end
          FN_AND:  begin wr = 1; wi = rd; wv = a & b; end
          FN_OR:   begin wr = 1; wi = rd; wv = a | b; end
          FN_XOR:  begin wr = 1; wi = rd; wv = a ^ b; end
          FN_NOR:  begin wr = 1; wi = rd; wv = ~(a | b); end
          FN_SLT:  begin wr = 1; wi = rd; wv = ($signed(a) < $signed(b)) ? 1 : 0; end
          FN_SLTU: begin wr = 1; wi = rd; wv = (a < b) ? 1 : 0; end
          FN_TGE:  if (!($signed(a) < $signed(b))) r.status = STATUS_TRAP;
          FN_TGEU: if (a >= b) r.status = STATUS_TRAP;
          FN_TLT:  if ($signed(a) < $signed(b)) r.status = STATUS_TRAP;
          FN_TLTU: if (a < b) r.status = STATUS_TRAP;
          FN_TEQ:  if (a == b) r.status = STATUS_TRAP;
          FN_TNE:  if (a != b) r.status = STATUS_TRAP;
          default: ;
        endcase
      end else begin
        case (op)
          OP_J:    nxt = {mdl_pc[31:28], ins[25:0], 2'b00};
          OP_JAL:  begin
            wr = 1; wi = REG_RA; wv = mdl_pc + 4;
            nxt = {mdl_pc[31:28], ins[25:0], 2'b00};
          end
          OP_BEQ:  if (a == b) nxt = mdl_pc + (simm << 2);
          OP_BNE:  if (a != b) nxt = mdl_pc + (simm << 2);
          OP_BLEZ: if (a == 0 || a[31]) nxt = mdl_pc + (simm << 2);
          OP_BGTZ: if (a != 0 && !a[31]) nxt = mdl_pc + (simm << 2);
          OP_ADDI: begin
            s = a + simm;
            if ((a[31] == simm[31]) && (s[31] != a[31])) r.status = STATUS_TRAP;
            else begin wr = 1; wi = rt; wv = s; end
          end
          OP_ADDIU: begin wr = 1; wi = rt; wv = a + simm; end
          OP_SLTI:  begin wr = 1; wi = rt; wv = ($signed(a) < $signed(simm)) ? 1 : 0; end
          OP_SLTIU: begin wr = 1; wi = rt; wv = (a < simm) ? 1 : 0; end
          OP_ANDI:  begin wr = 1; wi = rt; wv = a & {16'd0, ins[15:0]}; end
          OP_ORI:   begin wr = 1; wi = rt; wv = a | {16'd0, ins[15:0]}; end
          OP_XORI:  begin wr = 1; wi = rt; wv = a ^ {16'd0, ins[15:0]}; end
          OP_LUI:   begin wr = 1; wi = rt; wv = {ins[15:0], 16'd0}; end
          OP_LB: begin
            wr = 1; wi = rt;
            wv = {{24{mdl_mem[ea % MEM_BYTES][7]}}, mdl_mem[ea % MEM_BYTES]};
          end
          OP_LH: begin
            if (ea[0]) r.status = STATUS_TRAP;
            else begin
              wr = 1; wi = rt;
              wv = sx16({mdl_mem[(ea + 1) % MEM_BYTES], mdl_mem[ea % MEM_BYTES]});
            end
          end
          OP_LWL: begin
            w = mem_word({ea[31:2], 2'b00});
            wr = 1; wi = rt; wv = w << (8 * (3 - ea[1:0]));
          end
          OP_LWR: begin
            w = mem_word({ea[31:2], 2'b00});
            wr = 1; wi = rt; wv = w >> (8 * ea[1:0]);
          end
          default: ;
        endcase
      end
      if (wr && wi == 0) wr = 0;
      if (wr) mdl_gpr[wi] = wv;
      else begin wi = 0; wv = 0; end
      if (r.status == STATUS_OK) mdl_pc = nxt;
    end
    r.pc = mdl_pc;
    r.wr = wr;
    r.idx = wi;
    r.val = wv;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic put_item(logic mode, logic [13:0] addr, logic [31:0] data);
    item_t it;
    it.mode = mode; it.addr = addr; it.data = data;
    pending_q.push_back(it);
    n_queued++;
  endtask

  // Write one instruction at the generator PC, then step it.
  task automatic run_ins(logic [31:0] ins);
    put_item(1'b0, gen_pc[13:0], ins);
    put_item(1'b1, '0, '0);
  endtask

  function automatic logic [31:0] r_type(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_ins();
    logic [5:0] ops [19] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_J, OP_JAL, OP_BEQ,
      OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
      OP_XORI, OP_LUI, OP_LB, OP_LH};
    logic [5:0] fns [35] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_MOVZ, FN_MOVN, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
      FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
      FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ, FN_TNE};
    logic [31:0] ins;
    logic [5:0] op;
    int sel;
    ins = $urandom;
    sel = $urandom_range(0, 20);
    if (sel == 19) op = OP_LWL;
    else if (sel == 20) op = OP_LWR;
    else op = ops[sel];
    ins[31:26] = op;
    if (op == OP_SPECIAL) begin
      // mostly valid function codes, sometimes an unknown one
      if ($urandom_range(0, 15) != 0) ins[5:0] = fns[$urandom_range(0, 34)];
    end else if ($urandom_range(0, 40) == 0) begin
      ins[31:26] = 6'($urandom);
    end
    return ins;
  endfunction

  initial begin
    logic [31:0] ins;
    errors = 0; stim_done = 0;
    n_queued = 0; n_checked = 0;
    idle_pct_in = 0; stall_pct_out = 0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; mode_i = 1'b0; load_address_i = '0; load_data_i = '0;
    out_ready_i = 1'b0;
    for (int i = 0; i < MEM_BYTES; i++) mdl_mem[i] = '0;
    for (int i = 0; i < 32; i++) mdl_gpr[i] = '0;
    mdl_pc = 0; mdl_hi = 0; mdl_lo = 0;
    gen_pc = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: field extremes, overflow traps, lh misalignment, break,
    // divide by zero and the signed divide overflow case. After each step the
    // generator follows the model's PC, so a trap gets overwritten in place.
    begin
      logic [31:0] dir [$];
      dir = '{
        i_type(OP_LUI, 5'd0, 5'd1, 16'h8000),            // r1 = 0x80000000
        i_type(OP_ADDIU, 5'd0, 5'd2, 16'hffff),          // r2 = -1
        r_type(FN_ADD, 5'd1, 5'd1, 5'd3, 5'd0),          // overflow trap
        r_type(FN_SUB, 5'd1, 5'd2, 5'd0, 5'd0),          // r0 write discarded
        i_type(OP_ADDI, 5'd1, 5'd4, 16'hffff),           // overflow trap
        r_type(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0),          // min / -1
        r_type(FN_MFLO, 5'd0, 5'd0, 5'd5, 5'd0),
        r_type(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0),
        r_type(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0),         // divide by zero
        r_type(FN_MFLO, 5'd0, 5'd0, 5'd7, 5'd0),
        i_type(OP_LH, 5'd0, 5'd8, 16'h3fff),             // odd address trap
        i_type(OP_LB, 5'd2, 5'd9, 16'hffff),             // wraps
        i_type(OP_LWL, 5'd0, 5'd10, 16'h0001),
        i_type(OP_LWR, 5'd0, 5'd11, 16'h0003),
        i_type(OP_SLTIU, 5'd1, 5'd12, 16'h8000),
        r_type(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0),
        r_type(FN_MFHI, 5'd0, 5'd0, 5'd31, 5'd0),
        r_type(FN_BREAK, 5'd31, 5'd31, 5'd31, 5'd31),    // largest code
        r_type(FN_TEQ, 5'd0, 5'd0, 5'd0, 5'd0),
        {OP_JAL, 26'h3ff_ffff}
      };
      foreach (dir[i]) begin
        run_ins(dir[i]);
        wait (n_checked == n_queued);
        gen_pc = mdl_pc;
      end
    end
    put_item(1'b0, 14'h3fff, 32'hffff_ffff);   // top address, wraps to 0
    put_item(1'b0, 14'h0000, 32'h0000_0000);

    // Random part: the generator resyncs on the model PC whenever the core
    // has drained.
    for (int n = 0; n < 810; n++) begin
      if (n == 210) begin
        wait (n_checked == n_queued);
        idle_pct_in = 77; stall_pct_out = 0;
      end else if (n == 420) begin
        wait (n_checked == n_queued);
        idle_pct_in = 0; stall_pct_out = 77;
      end else if (n == 570) begin
        wait (n_checked == n_queued);
        idle_pct_in = 0; stall_pct_out = 0;
        // receiver holds off while a burst keeps the input busy
        hold_req++;
        for (int k = 0; k < 20; k++) put_item(1'b0, 14'($urandom), $urandom);
      end else if (n == 660) begin
        wait (n_checked == n_queued);
        idle_pct_in = 24; stall_pct_out = 24;
      end
      if (n % 30 == 0) begin
        // let the core catch up so mdl_pc reflects everything queued
        wait (n_checked == n_queued);
        gen_pc = mdl_pc;
        // seed some registers with interesting values
        for (int k = 1; k < 6; k++) begin
          ins = rand_operand();
          run_ins(i_type(OP_LUI, 5'd0, k[4:0], ins[31:16]));
          gen_pc = gen_pc + 4;
          run_ins(i_type(OP_ORI, k[4:0], k[4:0], ins[15:0]));
          gen_pc = gen_pc + 4;
        end
        n = n + 20;
        wait (n_checked == n_queued);
        gen_pc = mdl_pc;
      end
      if ($urandom_range(0, 9) == 0) begin
        put_item(1'b0, 14'($urandom), $urandom);   // noise write, possibly over code
      end else begin
        ins = rand_ins();
        ins[25:21] = 5'($urandom_range(0, 7));
        ins[20:16] = 5'($urandom_range(0, 7));
        run_ins(ins);
        // control flow makes the next PC unknown here; resync on the model
        wait (n_checked == n_queued);
        gen_pc = mdl_pc;
      end
    end
    stim_done = 1;
  end

  // ----------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) expected_q.push_back(core_step({mode_i, load_address_i, load_data_i}));
        if (pending_q.size() > 0 && $urandom_range(1, 100) > idle_pct_in) begin
          item_t it;
          it = pending_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= it.mode;
          load_address_i <= it.addr;
          load_data_i <= it.data;
        end else begin
          in_valid_i <= 1'b0;
          mode_i <= 1'($urandom);
          load_address_i <= 14'($urandom);
          load_data_i <= $urandom;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        step_res_t got, exp_r;
        got = {status_o, break_code_o, program_counter_o, reg_written_o,
               reg_index_o, reg_value_o};
        n_checked++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch exp st=%0d code=%h pc=%h wr=%0d idx=%0d val=%h",
                     $time, exp_r.status, exp_r.code, exp_r.pc, exp_r.wr, exp_r.idx,
                     exp_r.val);
            $display("%0t:          act st=%0d code=%h pc=%h wr=%0d idx=%0d val=%h",
                     $time, got.status, got.code, got.pc, got.wr, got.idx, got.val);
            errors++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------- receiver ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_ack != hold_req) begin
        hold_ack    <= hold_req;
        hold_cnt    <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(1, 100) > stall_pct_out);
      end
    end
  end

  // --------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (n_checked == n_queued && !in_valid_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (n_checked == n_queued);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/risc_pkg.sv
src/risc_div.sv
src/risc_ctrl.sv
src/risc_dp.sv
src/risc_instruction_step_core_top.sv
tb/tb_risc_instruction_step_core_top.sv
